### rtl/sfcr_pkg.sv
// types, codes and crc step for the stuffed frame crc receiver
package sfcr_pkg;

	localparam logic [7:0]  BYTE_START    = 8'hAE;
	localparam logic [7:0]  BYTE_ESCAPE   = 8'hAD;
	localparam logic [7:0]  ESC_CODE_ESC  = 8'h00;
	localparam logic [7:0]  ESC_CODE_STRT = 8'h01;
	localparam logic [15:0] CRC_POLY      = 16'h8408;
	localparam logic [15:0] CRC_SEED      = 16'hFFFF;
	localparam logic [7:0]  MAX_LEN_RESET = 8'd128;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_BAD     = 2'd2,
		KIND_ABORT   = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_LENGTH = 5'b00010,
		PH_DATA   = 5'b00100,
		PH_CRC_LO = 5'b01000,
		PH_CRC_HI = 5'b10000
	} phase_t;

	// reflected crc-16, one byte
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/stuffed_frame_crc_receiver.sv
// byte stuffed frame receiver with crc-16 check and payload output
// an accepted item is held in the input register, and its result is then held in the result register
// throughput: one item per cycle while the output is not stalled; unstuff and crc-16 step are combinational
// items that cause no result update the receiver state but put nothing on the output
// reset: arst_n clears phase, escape flag, counters, crc to ffff and max length to 128
module stuffed_frame_crc_receiver (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] result_kind,
	output logic [7:0] payload_byte,
	output logic [7:0] byte_index,
	output logic [7:0] frame_length
);
	import sfcr_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        adv;
	logic        accept;

	phase_t      phase_q, phase_d;
	logic        esc_q, esc_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  max_len_q;

	logic        res_v;
	kind_t       res_kind;
	logic [7:0]  res_byte;
	logic [7:0]  res_idx;
	logic [7:0]  res_len;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic [7:0]  idx_q;
	logic [7:0]  flen_q;

	logic [7:0]  d;
	logic        go;
	logic [7:0]  abort_len;
	logic [7:0]  cnt_inc;
	logic [15:0] crc_next;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

	// unescaped byte
	assign d = (esc_q && byte_s1 == ESC_CODE_ESC)  ? BYTE_ESCAPE :
	           (esc_q && byte_s1 == ESC_CODE_STRT) ? BYTE_START  : byte_s1;

	assign crc_next = crc_feed(crc_q, d);
	assign cnt_inc  = cnt_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		esc_d     = esc_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		crc_d     = crc_q;
		res_v     = 1'b0;
		res_kind  = KIND_PAYLOAD;
		res_byte  = 8'd0;
		res_idx   = 8'd0;
		res_len   = 8'd0;
		go        = 1'b0;
		abort_len = (phase_q == PH_LENGTH) ? 8'd0 : len_q;
		if (byte_s1 == BYTE_START) begin
			if (phase_q != PH_HEADER) begin
				res_v    = 1'b1;
				res_kind = KIND_ABORT;
				res_len  = abort_len;
			end
			phase_d = PH_LENGTH;
			esc_d   = 1'b0;
		end else if (phase_q != PH_HEADER) begin
			go = 1'b1;
			if (esc_q) begin
				esc_d = 1'b0;
				if (byte_s1 != ESC_CODE_ESC && byte_s1 != ESC_CODE_STRT) begin
					go       = 1'b0;
					res_v    = 1'b1;
					res_kind = KIND_ABORT;
					res_len  = abort_len;
					phase_d  = PH_HEADER;
				end
			end else if (byte_s1 == BYTE_ESCAPE) begin
				esc_d = 1'b1;
				go    = 1'b0;
			end
		end
		if (go) begin
			case (phase_q)
				PH_LENGTH: begin
					len_d = d;
					cnt_d = 8'd0;
					crc_d = CRC_SEED;
					if (d == 8'd0 || d > max_len_q) begin
						phase_d  = PH_HEADER;
						res_v    = 1'b1;
						res_kind = KIND_ABORT;
						res_len  = d;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: begin
					crc_d    = crc_next;
					cnt_d    = cnt_inc;
					if (cnt_inc == len_q) begin
						phase_d = PH_CRC_LO;
					end
					res_v    = 1'b1;
					res_kind = KIND_PAYLOAD;
					res_byte = d;
					res_idx  = cnt_q;
					res_len  = len_q;
				end
				PH_CRC_LO: begin
					crc_d   = crc_next;
					phase_d = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					crc_d    = crc_next;
					phase_d  = PH_HEADER;
					res_v    = 1'b1;
					res_kind = (crc_next == 16'd0) ? KIND_GOOD : KIND_BAD;
					res_len  = len_q;
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			esc_q   <= 1'b0;
			len_q   <= 8'd0;
			cnt_q   <= 8'd0;
			crc_q   <= CRC_SEED;
		end else if (adv) begin
			phase_q <= phase_d;
			esc_q   <= esc_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= adv && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			kind_q <= res_kind;
			byte_q <= res_byte;
			idx_q  <= res_idx;
			flen_q <= res_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = kind_q;
	assign payload_byte = byte_q;
	assign byte_index   = idx_q;
	assign frame_length = flen_q;

`ifndef NO_ASSERTIONS
	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && valid_s1))
		else $error("input stalled while result register free");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == KIND_PAYLOAD) |-> (byte_index < frame_length))
		else $error("payload index beyond declared length");

	a_end_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind != KIND_PAYLOAD) |->
			(payload_byte == 8'd0 && byte_index == 8'd0))
		else $error("frame end or abort carries payload fields");

	a_escape_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> (phase_q != PH_HEADER))
		else $error("escape pending outside a frame");
`endif

endmodule

### verif/testbench.sv
// self-checking testbench for the stuffed frame crc receiver
module testbench;
	import sfcr_pkg::*;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] pos;
		logic [7:0] len;
	} frame_event_t;

	typedef enum int {
		FLAW_NONE,
		FLAW_CRC,
		FLAW_CUT,
		FLAW_ESCAPE,
		FLAW_ESC_HEADER
	} flaw_t;

	localparam int QUIET_LIMIT   = 500;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_BYTES   = 35;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte     = 8'd0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic [1:0] result_kind;
	logic [7:0] payload_byte;
	logic [7:0] byte_index;
	logic [7:0] frame_length;

	// receiver state as predicted
	phase_t      rx_state      = PH_HEADER;
	logic        esc_seen      = 1'b0;
	logic [7:0]  declared_len  = 8'd0;
	logic [7:0]  payload_count = 8'd0;
	logic [15:0] crc_acc       = CRC_SEED;
	logic [7:0]  len_limit     = MAX_LEN_RESET;

	logic [7:0]   line_bytes [$];
	frame_event_t frame_events [$];

	int   in_hold      = 0;
	logic in_steady    = 1'b0;
	int   out_hold     = 0;
	logic out_steady   = 1'b0;
	int   quiet_cycles = 0;
	int   mismatches   = 0;
	int   bytes_queued = 0;
	int   bytes_taken  = 0;
	int   frames_built = 0;
	int   payload_seen = 0;
	int   good_seen    = 0;
	int   bad_seen     = 0;
	int   abort_seen   = 0;
	logic [7:0] random_limit = 8'd0;

	stuffed_frame_crc_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.frame_length (frame_length)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] crc_after_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		int          i;
		r = acc;
		for (i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = r >> 1;
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic unstuff_byte(input logic [7:0] raw);
		logic [7:0] d;
		logic [7:0] cut_len;
		d = raw;
		cut_len = (rx_state == PH_LENGTH) ? 8'd0 : declared_len;
		if (raw == BYTE_START) begin
			if (rx_state != PH_HEADER) begin
				frame_events.push_back(frame_event_t'{KIND_ABORT, 8'd0, 8'd0, cut_len});
			end
			rx_state = PH_LENGTH;
			esc_seen = 1'b0;
		end else if (rx_state == PH_HEADER) begin
			// line noise between frames
		end else if (esc_seen && raw != ESC_CODE_ESC && raw != ESC_CODE_STRT) begin
			esc_seen = 1'b0;
			rx_state = PH_HEADER;
			frame_events.push_back(frame_event_t'{KIND_ABORT, 8'd0, 8'd0, cut_len});
		end else if (!esc_seen && raw == BYTE_ESCAPE) begin
			esc_seen = 1'b1;
		end else begin
			if (esc_seen) begin
				d = (raw == ESC_CODE_ESC) ? BYTE_ESCAPE : BYTE_START;
			end
			esc_seen = 1'b0;
			case (rx_state)
				PH_LENGTH: begin
					declared_len = d;
					payload_count = 8'd0;
					crc_acc = CRC_SEED;
					if (d == 8'd0 || d > len_limit) begin
						rx_state = PH_HEADER;
						frame_events.push_back(frame_event_t'{KIND_ABORT, 8'd0, 8'd0, d});
					end else begin
						rx_state = PH_DATA;
					end
				end
				PH_DATA: begin
					frame_events.push_back(
						frame_event_t'{KIND_PAYLOAD, d, payload_count, declared_len});
					crc_acc = crc_after_byte(crc_acc, d);
					payload_count = payload_count + 8'd1;
					if (payload_count == declared_len) begin
						rx_state = PH_CRC_LO;
					end
				end
				PH_CRC_LO: begin
					crc_acc = crc_after_byte(crc_acc, d);
					rx_state = PH_CRC_HI;
				end
				PH_CRC_HI: begin
					crc_acc = crc_after_byte(crc_acc, d);
					rx_state = PH_HEADER;
					frame_events.push_back(frame_event_t'{
						(crc_acc == 16'd0) ? KIND_GOOD : KIND_BAD, 8'd0, 8'd0, declared_len});
				end
				default: begin
					rx_state = PH_HEADER;
				end
			endcase
		end
	endtask

	function automatic void push_line(input logic [7:0] b);
		line_bytes.push_back(b);
		bytes_queued++;
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8 || len_limit == 8'd0) begin
			if (len_limit == 8'd255 || $urandom_range(0, 1) == 0) begin
				return 0;
			end
			return $urandom_range(int'(len_limit) + 1, 255);
		end
		if (r == 8) begin
			return len_limit;
		end
		if (r < 14) begin
			return $urandom_range(1, (len_limit < 8'd40) ? int'(len_limit) : 40);
		end
		return $urandom_range(1, (len_limit < 8'd8) ? int'(len_limit) : 8);
	endfunction

	task automatic queue_frame(input int len, input flaw_t flaw, input bit codes_only);
		logic [7:0]  body [$];
		logic [7:0]  line [$];
		logic [7:0]  b;
		logic [15:0] crc;
		int          n;
		int          i;
		int          keep;
		int          at;
		body.push_back(8'(len));
		crc = CRC_SEED;
		n = (len == 0 || len > len_limit) ? $urandom_range(0, 3) : len;
		for (i = 0; i < n; i++) begin
			if (codes_only) begin
				b = ($urandom_range(0, 1) == 0) ? BYTE_START : BYTE_ESCAPE;
			end else begin
				case ($urandom_range(0, 7))
					0: b = BYTE_START;
					1: b = BYTE_ESCAPE;
					2: b = ESC_CODE_ESC;
					3: b = ESC_CODE_STRT;
					default: b = 8'($urandom_range(0, 255));
				endcase
			end
			body.push_back(b);
			crc = crc_after_byte(crc, b);
		end
		if (len != 0 && len <= len_limit) begin
			if (flaw == FLAW_CRC) begin
				crc = crc ^ (16'd1 << $urandom_range(0, 15));
			end
			body.push_back(crc[7:0]);
			body.push_back(crc[15:8]);
		end
		line.push_back(BYTE_START);
		for (i = 0; i < body.size(); i++) begin
			if (body[i] == BYTE_START) begin
				line.push_back(BYTE_ESCAPE);
				line.push_back(ESC_CODE_STRT);
			end else if (body[i] == BYTE_ESCAPE) begin
				line.push_back(BYTE_ESCAPE);
				line.push_back(ESC_CODE_ESC);
			end else begin
				line.push_back(body[i]);
			end
		end
		keep = line.size();
		if (flaw == FLAW_CUT || flaw == FLAW_ESC_HEADER) begin
			keep = $urandom_range(1, line.size() - 1);
		end
		at = $urandom_range(1, line.size() - 1);
		for (i = 0; i < keep; i++) begin
			if (flaw == FLAW_ESCAPE && i == at) begin
				push_line(BYTE_ESCAPE);
				b = 8'($urandom_range(2, 255));
				if (b == BYTE_START) begin
					b = 8'h02;
				end
				push_line(b);
			end
			push_line(line[i]);
		end
		if (flaw == FLAW_ESC_HEADER) begin
			push_line(BYTE_ESCAPE);
		end
		frames_built++;
	endtask

	task automatic wait_until_drained();
		while (line_bytes.size() != 0 || in_valid || frame_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// line byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_hold <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				unstuff_byte(rx_byte);
				bytes_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (in_hold != 0) begin
					in_valid <= 1'b0;
					in_hold <= in_hold - 1;
				end else if (line_bytes.size() != 0) begin
					rx_byte <= line_bytes.pop_front();
					in_valid <= 1'b1;
					in_hold <= in_steady ? 0 : $urandom_range(0, 3);
					if ($urandom_range(0, 59) == 0) begin
						in_steady <= !in_steady;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : watch_results
		frame_event_t want;
		int           hold_next;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold <= 0;
		end else begin
			hold_next = out_hold;
			if (out_valid && !out_stall) begin
				if (frame_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 40) begin
						$display("%0t: unexpected result kind %0d byte %02h index %0d length %0d",
							$time, result_kind, payload_byte, byte_index, frame_length);
					end
				end else begin
					want = frame_events.pop_front();
					if (result_kind !== want.kind || payload_byte !== want.data ||
							byte_index !== want.pos || frame_length !== want.len) begin
						mismatches++;
						if (mismatches <= 40) begin
							$display("%0t: expected kind %0d byte %02h index %0d length %0d,",
								$time, want.kind, want.data, want.pos, want.len,
								" got kind %0d byte %02h index %0d length %0d",
								result_kind, payload_byte, byte_index, frame_length);
						end
					end
					case (want.kind)
						KIND_PAYLOAD: payload_seen++;
						KIND_GOOD:    good_seen++;
						KIND_BAD:     bad_seen++;
						default:      abort_seen++;
					endcase
				end
				hold_next = out_steady ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 49) == 0) begin
					out_steady <= !out_steady;
				end
			end
			if (hold_next != 0) begin
				out_stall <= 1'b1;
				out_hold <= hold_next - 1;
			end else begin
				out_stall <= 1'b0;
				out_hold <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : run_phases
		int         phase_idx;
		int         budget;
		int         r;
		logic [7:0] next_limit;
		logic [7:0] noise;
		flaw_t      flaw;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames at the reset length limit
		push_line(8'h00);
		push_line(8'hFF);
		queue_frame(4, FLAW_NONE, 1'b1);
		queue_frame(1, FLAW_CRC, 1'b0);
		queue_frame(0, FLAW_NONE, 1'b0);
		queue_frame(129, FLAW_NONE, 1'b0);
		queue_frame(3, FLAW_CUT, 1'b0);
		queue_frame(2, FLAW_ESCAPE, 1'b0);
		queue_frame(1, FLAW_ESC_HEADER, 1'b0);
		queue_frame(1, FLAW_NONE, 1'b0);

		for (phase_idx = 0; phase_idx < 6; phase_idx++) begin
			if (phase_idx != 0) begin
				wait_until_drained();
				case (phase_idx)
					1: next_limit = 8'd1;
					2: next_limit = 8'd255;
					3: next_limit = 8'd0;
					4: begin
						next_limit = 8'($urandom_range(2, 254));
						random_limit = next_limit;
					end
					default: next_limit = MAX_LEN_RESET;
				endcase
				@(posedge clk);
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= next_limit;
				len_limit = next_limit;
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				if (len_limit == 8'd255) begin
					queue_frame(255, FLAW_NONE, 1'b0);
				end
			end
			budget = bytes_queued + PHASE_BYTES;
			while (bytes_queued < budget) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						noise = 8'($urandom_range(0, 255));
						if (noise == BYTE_START) begin
							noise = 8'h00;
						end
						push_line(noise);
					end
				end
				r = $urandom_range(0, 99);
				if (r < 62) begin
					flaw = FLAW_NONE;
				end else if (r < 74) begin
					flaw = FLAW_CRC;
				end else if (r < 84) begin
					flaw = FLAW_CUT;
				end else if (r < 93) begin
					flaw = FLAW_ESCAPE;
				end else begin
					flaw = FLAW_ESC_HEADER;
				end
				queue_frame(pick_length(), flaw, $urandom_range(0, 19) == 0);
			end
			queue_frame(pick_length(), FLAW_NONE, 1'b0);
		end

		wait_until_drained();
		$display("%0d line bytes in %0d frames, length limits 128, 1, 255, 0, %0d and 128",
			bytes_taken, frames_built, random_limit);
		$display("results seen: %0d payload bytes, %0d good crc, %0d bad crc, %0d aborts",
			payload_seen, good_seen, bad_seen, abort_seen);
		if (mismatches == 0 && frame_events.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### sim.f
rtl/sfcr_pkg.sv
rtl/stuffed_frame_crc_receiver.sv
verif/testbench.sv
